// File: hdl/bdmd_pkg.sv
// Package for the block delta/mask decoder: widths, item codes, sequencer
// states and the saturating adder. No dependencies.
`default_nettype none

package bdmd_pkg;

  // Field widths fixed by the item format
  localparam int unsigned SampleW = 32;
  localparam int unsigned MaskW   = 32;

  // Default number of samples in one block
  localparam int unsigned BdmdBlockLen = 32;

  // Saturation limits
  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  // Item type codes
  localparam logic ReqHeader = 1'b0;
  localparam logic ReqValue  = 1'b1;

  // Block mode codes
  localparam logic ModeDelta  = 1'b0;
  localparam logic ModeMasked = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StValue,
    StRun
  } state_e;

  // Add two signed samples and clamp to the signed sample range
  function automatic logic signed [SampleW-1:0] sat_add(
    input logic signed [SampleW-1:0] a,
    input logic signed [SampleW-1:0] b
  );
    logic signed [SampleW:0] s;
    s = {a[SampleW-1], a} + {b[SampleW-1], b};
    if (s[SampleW] != s[SampleW-1]) begin
      return s[SampleW] ? SampleMin : SampleMax;
    end
    return s[SampleW-1:0];
  endfunction

endpackage

`default_nettype wire

// File: hdl/block_delta_mask_decoder.sv
// Top level of the block delta/mask decoder: sequencer, shared saturating
// adder, mask shifter and output register. Depends on bdmd_pkg.
`default_nettype none

// Block decoder for signed fixed-point samples. A header item opens a block of
// BlockLen samples, either in delta mode (each value item adds to a running sum
// that is emitted) or in masked mode (a set mask bit, MSB first, takes a value
// item and emits value plus base; a clear bit emits the base alone). In delta
// mode a value item that finds a block open is accepted in idle and then forms
// its sample in the shared saturating adder in the value state. In masked mode
// it then goes on to the run state, which emits the base for each clear mask
// position that follows before returning to idle. A header is accepted in idle,
// then in masked mode the run state emits the base for each clear position that
// follows before returning to idle; each emitted sample waits for the output
// register to drain. The input is not ready while an item is being worked on.
// Value items with no open block are dropped; a header abandons any open block.
module block_delta_mask_decoder
  import bdmd_pkg::*;
#(
  parameter int unsigned BlockLen = BdmdBlockLen
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input items
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic                      req_type_i,
  input  wire logic                      block_mode_i,
  input  wire logic signed [SampleW-1:0] base_value_i,
  input  wire logic        [MaskW-1:0]   present_mask_i,
  input  wire logic signed [SampleW-1:0] coded_value_i,
  // result items
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic signed [SampleW-1:0] sample_o,
  output      logic                      block_last_o
);

  localparam int unsigned PosW = (BlockLen > 1) ? $clog2(BlockLen) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(BlockLen - 1);

  state_e                    state_q, state_d;
  logic                      open_q, open_d;
  logic                      mode_q, mode_d;
  logic signed [SampleW-1:0] base_q, base_d;
  logic        [MaskW-1:0]   mask_q, mask_d;
  logic        [PosW-1:0]    pos_q, pos_d;
  logic signed [SampleW-1:0] sum_q, sum_d;
  logic signed [SampleW-1:0] coded_q, coded_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [SampleW-1:0] sample_q, sample_d;
  logic                      last_q, last_d;

  logic                      slot_free;
  logic                      emit;
  logic                      emit_last;
  logic signed [SampleW-1:0] emit_sample;
  logic signed [SampleW-1:0] add_a;
  logic signed [SampleW-1:0] add_res;

  // Shared saturating adder: running sum in delta mode, base in masked mode
  assign add_a   = (mode_q == ModeMasked) ? base_q : sum_q;
  assign add_res = sat_add(add_a, coded_q);

  // Output register can take a sample when empty or draining this cycle
  assign slot_free = !out_valid_q || out_ready_i;

  // Sequencer: next state, block state and emit control
  always_comb begin
    state_d     = state_q;
    open_d      = open_q;
    mode_d      = mode_q;
    base_d      = base_q;
    mask_d      = mask_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    coded_d     = coded_q;
    in_ready_o  = 1'b0;
    emit        = 1'b0;
    emit_sample = base_q;

    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == ReqHeader) begin
            open_d  = 1'b1;
            mode_d  = block_mode_i;
            base_d  = base_value_i;
            mask_d  = present_mask_i;
            pos_d   = '0;
            sum_d   = '0;
            state_d = StRun;
          end else if (open_q) begin
            coded_d = coded_value_i;
            state_d = StValue;
          end
        end
      end
      StValue: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_sample = add_res;
          if (mode_q == ModeDelta) begin
            sum_d   = add_res;
            state_d = StIdle;
          end else begin
            state_d = StRun;
          end
        end
      end
      StRun: begin
        // emit base for every clear position reached
        if (open_q && (mode_q == ModeMasked) && !mask_q[MaskW-1]) begin
          if (slot_free) begin
            emit = 1'b1;
          end
        end else begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Advance position and mask on each emitted sample; close at block end
    emit_last = (pos_q == PosLast);
    if (emit) begin
      mask_d = {mask_q[MaskW-2:0], 1'b0};
      if (emit_last) begin
        pos_d  = '0;
        open_d = 1'b0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    sample_d = sample_q;
    last_d   = last_q;
    if (emit) begin
      out_valid_d = 1'b1;
      sample_d    = emit_sample;
      last_d      = emit_last;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and block state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      open_q      <= 1'b0;
      mode_q      <= ModeDelta;
      base_q      <= '0;
      mask_q      <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      mode_q      <= mode_d;
      base_q      <= base_d;
      mask_q      <= mask_d;
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    coded_q  <= coded_d;
    sample_q <= sample_d;
    last_q   <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_o     = sample_q;
  assign block_last_o = last_q;

endmodule

`default_nettype wire

// File: hdl/bdmd_checker.sv
// Port-level checker for the block delta/mask decoder and its bind.
// Depends on bdmd_pkg and block_delta_mask_decoder.
`default_nettype none

module bdmd_checker
  import bdmd_pkg::*;
(
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic                      req_type_i,
  input wire logic                      block_mode_i,
  input wire logic        [MaskW-1:0]   present_mask_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic signed [SampleW-1:0] sample_o,
  input wire logic                      block_last_o
);

  // Hold a stalled result item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sample_o) && $stable(block_last_o))
    else $error("result item changed while stalled");

  // A header leaves the input not ready in the cycle after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == ReqHeader) |=> !in_ready_o)
    else $error("input ready right after a header item");

  // A masked header with a clear first bit emits the base from StRun
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (req_type_i == ReqHeader) &&
    (block_mode_i == ModeMasked) && !present_mask_i[MaskW-1] && !out_valid_o
    |=> ##1 out_valid_o)
    else $error("leading clear position not emitted");

endmodule

bind block_delta_mask_decoder bdmd_checker u_bdmd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .req_type_i     (req_type_i),
  .block_mode_i   (block_mode_i),
  .present_mask_i (present_mask_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .sample_o       (sample_o),
  .block_last_o   (block_last_o)
);

`default_nettype wire
